// ----- sv/can_bt_pkg.sv -----
// Package for the CAN bit timing solver: field widths, search limits and
// the segment split for a given quanta count. No dependencies.
package can_bt_pkg;

	localparam int CLK_W   = 27;
	localparam int RATE_W  = 23;
	localparam int TQ_W    = 5;
	localparam int DEN_W   = RATE_W + TQ_W;
	localparam int PRESC_W = 10;
	localparam int SEG_W   = 5;
	localparam int SJW_W   = 3;
	localparam int CNT_W   = 5;

	localparam logic [TQ_W-1:0]    TQ_MAX    = 5'd25;
	localparam logic [TQ_W-1:0]    TQ_MIN    = 5'd8;
	localparam logic [CLK_W-1:0]   PRESC_MAX = 27'd512;
	localparam logic [SEG_W-1:0]   SJW_CAP   = 5'd4;
	localparam logic [CLK_W-1:0]   KCLK_RESET = 27'd25000000;
	localparam logic [CNT_W-1:0]   DIV_STEPS_M1 = 5'(CLK_W - 1);

	localparam logic REG_KCLK = 1'b0;

	typedef struct packed {
		logic [SEG_W-1:0] seg1;
		logic [SEG_W-1:0] seg2;
		logic [SJW_W-1:0] sjw;
	} seg_split_t;

	// Sample point near 87.5%: span = floor(7t/8), at most t-2 (t >= 8 here).
	function automatic seg_split_t seg_split(input logic [TQ_W-1:0] total);
		logic [7:0] span;
		logic [7:0] tmax;
		logic [SEG_W-1:0] s2;
		seg_split_t r;
		span = (8'(total) * 8'd7) >> 3;
		tmax = 8'(total) - 8'd2;
		if (span > tmax)
			span = tmax;
		s2 = total - span[SEG_W-1:0];
		r.seg1 = span[SEG_W-1:0] - 5'd1;
		r.seg2 = s2;
		r.sjw  = (s2 < SJW_CAP) ? s2[SJW_W-1:0] : SJW_CAP[SJW_W-1:0];
		return r;
	endfunction

endpackage

// ----- sv/can_bit_timing_solver_top.sv -----
// CAN nominal bit timing solver, top level. Bit-serial restoring divider
// over candidate quanta counts 25 down to 8. Depends on can_bt_pkg.
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------
// request  | start / busy         | bitrate
// result   | done (1 cycle)       | found, prescaler, seg1, seg2, jump_width
// config   | APB psel/penable/... | kernel_clock_hz at byte address 0
//
// Each candidate count passes ST_MUL for rate*count, ST_DIV for the
// one-bit-per-cycle division of the kernel clock, and ST_CHECK.
// A zero bitrate goes through ST_FAIL alone; otherwise the run time is
// set by the number of candidates tried before an exact divisor is hit.
// arst_n clears the sequencer and loads the clock register with 25 MHz.
// The receiver cannot stall: done is high for one cycle per request.
module can_bit_timing_solver_top
	import can_bt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [RATE_W-1:0]    bitrate,
	output logic                 done,
	output logic                 found,
	output logic [PRESC_W-1:0]   prescaler,
	output logic [SEG_W-1:0]     seg1,
	output logic [SEG_W-1:0]     seg2,
	output logic [SJW_W-1:0]     jump_width,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_FAIL  = 3'd4;

	logic [2:0]          state_q;
	logic [CLK_W-1:0]    kclk_q;
	logic [RATE_W-1:0]   rate_q;
	logic [TQ_W-1:0]     total_q;
	logic [DEN_W-1:0]    denom_q;
	logic [DEN_W-1:0]    rem_q;
	logic [CLK_W-1:0]    quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic                found_q;
	logic [PRESC_W-1:0]  presc_q;
	logic [SEG_W-1:0]    seg1_q;
	logic [SEG_W-1:0]    seg2_q;
	logic [SJW_W-1:0]    sjw_q;

	logic                reg_idx;
	logic                cfg_wr;
	logic [DEN_W:0]      trial;
	logic [DEN_W:0]      diff;
	logic                fits;
	logic                exact;
	seg_split_t          split;

	// paddr[1:0] are byte lanes within the word
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_KCLK);
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_KCLK) ? {5'd0, kclk_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kclk_q <= KCLK_RESET;
		else if (cfg_wr)
			kclk_q <= pwdata[CLK_W-1:0];
	end

	// one quotient bit per cycle, dividend bits shifted in from the top of quo_q
	assign trial = {rem_q, quo_q[CLK_W-1]};
	assign diff  = trial - {1'b0, denom_q};
	assign fits  = !diff[DEN_W];

	assign exact = (rem_q == '0) && (quo_q != '0) && (quo_q <= PRESC_MAX);
	assign split = seg_split(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= (bitrate == '0) ? ST_FAIL : ST_MUL;
				end
				ST_MUL:   state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (exact || total_q == TQ_MIN) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_FAIL: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rate_q  <= bitrate;
				total_q <= TQ_MAX;
			end
			ST_MUL: begin
				denom_q <= DEN_W'(rate_q) * DEN_W'(total_q);
				rem_q   <= '0;
				quo_q   <= kclk_q;
				cnt_q   <= DIV_STEPS_M1;
			end
			ST_DIV: begin
				rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_q <= {quo_q[CLK_W-2:0], fits};
				cnt_q <= cnt_q - 5'd1;
			end
			ST_CHECK: begin
				total_q <= total_q - 5'd1;
				found_q <= exact;
				presc_q <= exact ? quo_q[PRESC_W-1:0] : '0;
				seg1_q  <= exact ? split.seg1 : '0;
				seg2_q  <= exact ? split.seg2 : '0;
				sjw_q   <= exact ? split.sjw : '0;
			end
			ST_FAIL: begin
				found_q <= 1'b0;
				presc_q <= '0;
				seg1_q  <= '0;
				seg2_q  <= '0;
				sjw_q   <= '0;
			end
			default: ;
		endcase
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign found      = found_q;
	assign prescaler  = presc_q;
	assign seg1       = seg1_q;
	assign seg2       = seg2_q;
	assign jump_width = sjw_q;

endmodule

// ----- verif/can_bit_timing_solver_top_tb.sv -----
// Testbench for can_bit_timing_solver_top: bitrate requests checked against a
// behavioral timing search, over several kernel clock settings set through APB.
// Depends on can_bt_pkg and can_bit_timing_solver_top only.
`timescale 1ns / 1ps

module can_bit_timing_solver_top_tb;
	import can_bt_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 600;
	localparam int ITEMS_PER_SETTING = 100;
	localparam logic [2:0] KCLK_ADDR = 3'(4 * REG_KCLK);
	localparam logic [2:0] SPARE_ADDR = 3'd4;   // no register behind it

	typedef struct {
		logic [RATE_W-1:0]  rate;
		logic               found;
		logic [PRESC_W-1:0] presc;
		logic [SEG_W-1:0]   s1;
		logic [SEG_W-1:0]   s2;
		logic [SJW_W-1:0]   sjw;
	} timing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [RATE_W-1:0] bitrate = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic busy, done, found, pready;
	logic [PRESC_W-1:0] prescaler;
	logic [SEG_W-1:0] seg1, seg2;
	logic [SJW_W-1:0] jump_width;
	logic [31:0] prdata;

	logic [RATE_W-1:0] rate_q[$];
	timing_t timing_exp[$];
	logic [CLK_W-1:0] kclk_model = KCLK_RESET;
	int n_err = 0;
	int n_sent = 0;
	int n_found = 0;
	int n_settings = 1;
	int cycles = 0;
	int gap_left = 0;
	bit no_gaps = 1'b0;

	can_bit_timing_solver_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.bitrate    (bitrate),
		.done       (done),
		.found      (found),
		.prescaler  (prescaler),
		.seg1       (seg1),
		.seg2       (seg2),
		.jump_width (jump_width),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #10 clk = ~clk;

	// Largest quanta count first; first exact prescaler in range wins.
	function automatic timing_t solve_timing(input logic [CLK_W-1:0] kclk,
			input logic [RATE_W-1:0] rate);
		timing_t r;
		logic [63:0] den, pre;
		int t, span, s1, s2;
		r = '{rate: rate, found: 1'b0, presc: '0, s1: '0, s2: '0, sjw: '0};
		if (rate == '0)
			return r;
		for (t = int'(TQ_MAX); t >= int'(TQ_MIN); t--) begin
			den = 64'(rate) * 64'(t);
			if (64'(kclk) % den != 0)
				continue;
			pre = 64'(kclk) / den;
			if (pre < 1 || pre > 64'(PRESC_MAX))
				continue;
			span = (t * 7) / 8;
			if (span < 2)
				span = 2;
			if (span > t - 2)
				span = t - 2;
			s1 = span - 1;
			s2 = t - 1 - s1;
			if (s1 < 2 || s2 < 2)
				continue;
			r.found = 1'b1;
			r.presc = PRESC_W'(pre);
			r.s1 = SEG_W'(s1);
			r.s2 = SEG_W'(s2);
			r.sjw = SJW_W'((s2 < int'(SJW_CAP)) ? s2 : int'(SJW_CAP));
			return r;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Mostly rates near the clock divided by some count and prescaler, plus
	// zero, common CAN rates, small values and raw noise.
	function automatic logic [RATE_W-1:0] pick_rate(input logic [CLK_W-1:0] kclk);
		int r, t, p;
		logic [31:0] v;
		int std_rates[9] = '{10000, 20000, 50000, 100000, 125000, 250000, 500000,
			800000, 1000000};
		r = $urandom_range(0, 99);
		if (r < 2)
			return '0;
		if (r < 60) begin
			t = $urandom_range(int'(TQ_MIN), int'(TQ_MAX));
			p = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 32) : $urandom_range(1, 512);
			v = 32'(kclk) / 32'(t * p);
			return (v == 0) ? RATE_W'(1) : RATE_W'(v);
		end
		if (r < 72)
			return RATE_W'(std_rates[$urandom_range(0, 8)]);
		if (r < 85)
			return RATE_W'($urandom_range(1, 2000));
		return RATE_W'($urandom());
	endfunction

	task automatic report_err(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		n_err++;
	endtask

	task automatic check_field(input string name, input int got, input int want,
			input logic [RATE_W-1:0] rate);
		if (got != want)
			report_err($sformatf("%s: got %0d, want %0d (bitrate %0d, kclk %0d)",
				name, got, want, rate, kclk_model));
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == KCLK_ADDR)
			kclk_model = data[CLK_W-1:0];
	endtask

	task automatic wait_quiet();
		while (rate_q.size() != 0 || start || timing_exp.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Request driver: holds start until the transfer, then picks a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				timing_exp.push_back(solve_timing(kclk_model, bitrate));
				if (timing_exp[$].found)
					n_found++;
				n_sent++;
				gap_left = pick_gap();
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (rate_q.size() != 0) begin
					start <= 1'b1;
					bitrate <= rate_q.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor: one transfer per done cycle.
	always @(posedge clk) begin
		timing_t want;
		if (arst_n && done) begin
			if (timing_exp.size() == 0) begin
				report_err("result with no request outstanding");
			end else begin
				want = timing_exp.pop_front();
				check_field("found", found, want.found, want.rate);
				check_field("prescaler", prescaler, want.presc, want.rate);
				check_field("seg1", seg1, want.s1, want.rate);
				check_field("seg2", seg2, want.s2, want.rate);
				check_field("jump_width", jump_width, want.sjw, want.rate);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("can_bit_timing_solver_top_tb: errors");
			$finish;
		end
	end

	initial begin
		logic [CLK_W-1:0] kclk_list[10];
		logic [RATE_W-1:0] directed[18];
		int ph, i;

		directed = '{
			23'd0, 23'd1, 23'h7FFFFF, 23'd8000000, 23'd1000000, 23'd500000,
			23'd125000, 23'd250000, 23'd3125000, 23'd1000, 23'd20000, 23'd400000,
			23'd2500000, 23'd1562500, 23'd1250000, 23'd1041666, 23'h555555, 23'h2AAAAA};
		kclk_list = '{27'd1000000, 27'd100000000, 27'd67108864, 27'd80000000, 27'd0,
			27'h7FFFFFF, 27'd48000000, 27'd24000000,
			27'($urandom_range(1000000, 100000000)), 27'd25000000};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset value of the clock register first: directed rates, then random ones
		foreach (directed[k])
			rate_q.push_back(directed[k]);
		for (i = 0; i < ITEMS_PER_SETTING; i++)
			rate_q.push_back(pick_rate(kclk_model));
		wait_quiet();

		for (ph = 0; ph < 10; ph++) begin
			no_gaps = (ph % 3 == 2);
			write_reg(KCLK_ADDR, {5'b0, kclk_list[ph]});
			if (ph == 4)
				write_reg(SPARE_ADDR, $urandom());   // must leave the clock alone
			n_settings++;
			@(negedge clk);
			if (kclk_list[ph] == 27'd67108864)
				rate_q.push_back(23'd8192);           // prescaler at its ceiling
			rate_q.push_back(23'h7FFFFF);
			rate_q.push_back(23'd0);
			for (i = 0; i < ITEMS_PER_SETTING - 10; i++)
				rate_q.push_back(pick_rate(kclk_model));
			wait_quiet();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (timing_exp.size() != 0)
			report_err($sformatf("%0d results never arrived", timing_exp.size()));
		$display("%0d requests over %0d clock settings, %0d with a timing found",
			n_sent, n_settings, n_found);
		if (n_err == 0) begin
			$display("can_bit_timing_solver_top_tb: clean");
		end else begin
			$display("%0d mismatches", n_err);
			$display("can_bit_timing_solver_top_tb: errors");
		end
		$finish;
	end

endmodule
